// ===== design/ffcc_pkg.sv =====
// shared types and constants of the fat free cluster counter
package ffcc_pkg;

   localparam int BYTE_W    = 8;
   localparam int FAT_W     = 19;
   localparam int CLUSTER_W = 28;
   localparam int LIMIT_W   = 29;
   localparam int POS_W     = 18;
   localparam int CAP_W     = 18;
   localparam int ENTRY_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [FAT_W-1:0]     MAX_TABLE_BYTES = 19'd262144;
   localparam logic [FAT_W-1:0]     FAT_BYTES_RESET = 19'd512;
   localparam logic [CLUSTER_W-1:0] CLUSTER_RESET   = 28'd2;
   localparam logic [POS_W-1:0]     POS_MAX         = 18'h3FFFF;

   // floor(x/3) = (x * DIV3_MUL) >> DIV3_SHIFT for any x below 2**20
   localparam int                DIV3_SHIFT = 21;
   localparam int                DIV3_IN_W  = FAT_W + 1;
   localparam logic [19:0]       DIV3_MUL   = 20'((2**DIV3_SHIFT + 2) / 3);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IS_FAT12      = 2'd0,
      CSR_FAT_BYTES     = 2'd1,
      CSR_CLUSTER_COUNT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                 busy;
      logic                 is_fat12;
      logic [LIMIT_W-1:0]   entry_limit;
      logic [CLUSTER_W-1:0] extra;
   } limit_info_type;

endpackage

// ===== design/ffcc_cfg.sv =====
// configuration registers and the entry limit / free offset pipeline
module ffcc_cfg #(
   parameter logic [ffcc_pkg::FAT_W-1:0]   MAX_TABLE_BYTES = ffcc_pkg::MAX_TABLE_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ffcc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ffcc_pkg::CLUSTER_W-1:0]  csr_data,
   output ffcc_pkg::limit_info_type        limit_info
);

   logic                           is_fat12_ff;
   logic [ffcc_pkg::FAT_W-1:0]     fat_bytes_ff;
   logic [ffcc_pkg::CLUSTER_W-1:0] cluster_ff;
   logic [ffcc_pkg::CAP_W-1:0]     cap_ff;
   logic [ffcc_pkg::CAP_W-1:0]     cap_in;
   logic [ffcc_pkg::LIMIT_W-1:0]   limit_ff;
   logic [ffcc_pkg::LIMIT_W-1:0]   limit_in;
   logic [ffcc_pkg::CLUSTER_W-1:0] extra_ff;
   logic [ffcc_pkg::CLUSTER_W-1:0] extra_in;
   logic [1:0]                     busy_ff;

   logic [ffcc_pkg::FAT_W-1:0]     clamped;
   logic [ffcc_pkg::DIV3_IN_W-1:0] twice;
   logic [39:0]                    product;
   logic [ffcc_pkg::LIMIT_W-1:0]   top;
   logic [ffcc_pkg::LIMIT_W-1:0]   scanned;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         is_fat12_ff  <= 1'b0;
         fat_bytes_ff <= ffcc_pkg::FAT_BYTES_RESET;
         cluster_ff   <= ffcc_pkg::CLUSTER_RESET;
         busy_ff      <= 2'd3;
      end else begin
         if (csr_valid) begin
            busy_ff <= 2'd3;
            unique case (csr_index)
               ffcc_pkg::CSR_IS_FAT12:      is_fat12_ff  <= csr_data[0];
               ffcc_pkg::CSR_FAT_BYTES:     fat_bytes_ff <= csr_data[ffcc_pkg::FAT_W-1:0];
               ffcc_pkg::CSR_CLUSTER_COUNT: cluster_ff   <= csr_data;
               default: ;
            endcase
         end else if (busy_ff != 2'd0) begin
            busy_ff <= busy_ff - 2'd1;
         end
      end
   end

   // stage 1: entry capacity of the table
   always_comb begin
      clamped = (fat_bytes_ff > MAX_TABLE_BYTES) ? MAX_TABLE_BYTES : fat_bytes_ff;
      twice   = {clamped, 1'b0};
      product = 40'(twice) * 40'(ffcc_pkg::DIV3_MUL);
      if (is_fat12_ff) begin
         cap_in = product[ffcc_pkg::DIV3_SHIFT +: ffcc_pkg::CAP_W];
      end else begin
         cap_in = clamped[ffcc_pkg::FAT_W-1:1];
      end
   end

   // stage 2: limit, stage 3: clusters beyond the scanned range
   always_comb begin
      top      = {1'b0, cluster_ff} + ffcc_pkg::LIMIT_W'(2);
      limit_in = (ffcc_pkg::LIMIT_W'(cap_ff) < top) ? ffcc_pkg::LIMIT_W'(cap_ff) : top;
      scanned  = (limit_ff >= ffcc_pkg::LIMIT_W'(2)) ? limit_ff - ffcc_pkg::LIMIT_W'(2)
                                                    : '0;
      extra_in = ({1'b0, cluster_ff} > scanned)
                 ? cluster_ff - scanned[ffcc_pkg::CLUSTER_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      cap_ff   <= cap_in;
      limit_ff <= limit_in;
      extra_ff <= extra_in;
   end

   always_comb begin
      limit_info.busy        = (busy_ff != 2'd0);
      limit_info.is_fat12    = is_fat12_ff;
      limit_info.entry_limit = limit_ff;
      limit_info.extra       = extra_ff;
   end

endmodule

// ===== design/ffcc_scan.sv =====
// entry unpacking and zero tally state, one table byte per cycle while fire is high
module ffcc_scan (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fire,
   input  logic [ffcc_pkg::BYTE_W-1:0]     in_byte,
   input  logic                            in_last,
   input  ffcc_pkg::limit_info_type        limit_info,
   output logic [ffcc_pkg::CLUSTER_W-1:0]  result
);

   logic [ffcc_pkg::POS_W-1:0]   pos_ff;
   logic [ffcc_pkg::POS_W-1:0]   pos_in;
   logic [1:0]                   phase_ff;
   logic [1:0]                   phase_in;
   logic [ffcc_pkg::BYTE_W-1:0]  held_ff;
   logic [ffcc_pkg::BYTE_W-1:0]  held_in;
   logic [ffcc_pkg::POS_W-1:0]   entry_pos_ff;
   logic [ffcc_pkg::POS_W-1:0]   entry_pos_in;
   logic [ffcc_pkg::POS_W-1:0]   tally_ff;
   logic [ffcc_pkg::POS_W-1:0]   tally_in;

   logic                         take;
   logic                         counted;
   logic [ffcc_pkg::ENTRY_W-1:0] entry;

   always_comb begin
      take    = 1'b0;
      entry   = '0;
      held_in = held_ff;
      if (limit_info.is_fat12) begin
         unique case (phase_ff)
            2'd0: held_in = in_byte;
            2'd1: begin
               take    = 1'b1;
               entry   = {4'b0, in_byte[3:0], held_ff};
               held_in = in_byte;
            end
            2'd2: begin
               take  = 1'b1;
               entry = {4'b0, in_byte, held_ff[7:4]};
            end
            default: ;
         endcase
      end else if (pos_ff[0]) begin
         take  = 1'b1;
         entry = {in_byte, held_ff};
      end else begin
         held_in = in_byte;
      end

      counted      = take && (ffcc_pkg::LIMIT_W'(entry_pos_ff) < limit_info.entry_limit);
      entry_pos_in = entry_pos_ff + ffcc_pkg::POS_W'(counted);
      tally_in     = tally_ff + ffcc_pkg::POS_W'(counted
                     && (entry_pos_ff >= ffcc_pkg::POS_W'(2)) && (entry == '0));

      // position saturates; the saturated value is a multiple of three
      if (pos_ff < ffcc_pkg::POS_MAX) begin
         pos_in   = pos_ff + ffcc_pkg::POS_W'(1);
         phase_in = (phase_ff == 2'd2) ? 2'd0 : phase_ff + 2'd1;
      end else begin
         pos_in   = pos_ff;
         phase_in = phase_ff;
      end

      result = ffcc_pkg::CLUSTER_W'(tally_in) + limit_info.extra;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         phase_ff     <= 2'd0;
         held_ff      <= '0;
         entry_pos_ff <= '0;
         tally_ff     <= '0;
      end else if (fire) begin
         if (in_last) begin
            pos_ff       <= '0;
            phase_ff     <= 2'd0;
            held_ff      <= '0;
            entry_pos_ff <= '0;
            tally_ff     <= '0;
         end else begin
            pos_ff       <= pos_in;
            phase_ff     <= phase_in;
            held_ff      <= held_in;
            entry_pos_ff <= entry_pos_in;
            tally_ff     <= tally_in;
         end
      end
   end

endmodule

// ===== design/fat_free_cluster_counter.sv =====
// top level of the fat free cluster counter: stream registers and handshake
// Counts free clusters of a FAT12 or FAT16 table streamed one byte per item and
// returns the count once, on the item marked tlast. Bytes are taken one per
// cycle while req_tready is high; an item passes an input register and the scan
// logic, and its result is registered in the output register when the last
// byte leaves the input register. The input stage stalls only when a last byte
// meets an output register still holding an untaken result. After reset and
// after each configuration write, req_tready stays low while the limit pipeline
// (divide-by-three multiplier, minimum against cluster_count+2, offset of
// unscanned clusters) settles.
module fat_free_cluster_counter #(
   parameter logic [ffcc_pkg::FAT_W-1:0]   MAX_TABLE_BYTES = ffcc_pkg::MAX_TABLE_BYTES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] fat_byte
   input  logic                            req_tlast,   // last_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,   // [27:0] free_count
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ffcc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ffcc_pkg::CLUSTER_W-1:0]  csr_data
);

   ffcc_pkg::limit_info_type limit_info;

   logic                           in_valid_ff;
   logic [ffcc_pkg::BYTE_W-1:0]    in_byte_ff;
   logic                           in_last_ff;
   logic                           rsp_valid_ff;
   logic [ffcc_pkg::CLUSTER_W-1:0] rsp_data_ff;
   logic [ffcc_pkg::CLUSTER_W-1:0] result;
   logic                           out_free;
   logic                           fire;

   ffcc_cfg #(
      .MAX_TABLE_BYTES (MAX_TABLE_BYTES)
   ) u_cfg (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .limit_info (limit_info)
   );

   ffcc_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .in_byte    (in_byte_ff),
      .in_last    (in_last_ff),
      .limit_info (limit_info),
      .result     (result)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !limit_info.busy && (!in_valid_ff || fire);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_data_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && in_last_ff) begin
         rsp_data_ff <= result;
      end
   end

   // a configuration write holds off input while the limit settles
   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_tready)
      else $error("input accepted right after a configuration write");

   // a result appears only after a last byte left the input stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(in_valid_ff && in_last_ff))
      else $error("result without a last byte");

   // the input stage waits only on a full, stalled output register
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |-> in_last_ff && rsp_tvalid && !rsp_tready)
      else $error("input stage stalled without cause");

endmodule

// ===== test/fat_free_cluster_counter_tb.sv =====
// testbench of the fat free cluster counter: directed tables, then random tables
module fat_free_cluster_counter_tb;

   localparam int ITEM_TARGET   = 1550;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 6;
   localparam int MAX_GAP       = 10;
   localparam int DIRECTED_ROWS = 33;

   // index with no register behind it, writes there are ignored
   localparam logic [ffcc_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic {ROW_CSR, ROW_BYTE} row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [ffcc_pkg::CSR_IDX_W-1:0] index;
      logic [ffcc_pkg::CLUSTER_W-1:0] value;
      logic                           last;
      logic                           typed;
      logic [ffcc_pkg::CLUSTER_W-1:0] want;
   } stim_row_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [7:0]                     req_tdata  = '0;
   logic                           req_tlast  = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [31:0]                    rsp_tdata;
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [ffcc_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [ffcc_pkg::CLUSTER_W-1:0] csr_data   = '0;

   // mirror of the block: settings and scan state
   logic                           mode_fat12;
   logic [ffcc_pkg::FAT_W-1:0]     table_bytes;
   logic [ffcc_pkg::CLUSTER_W-1:0] clusters;
   logic [ffcc_pkg::POS_W-1:0]     byte_pos;
   logic [ffcc_pkg::BYTE_W-1:0]    held;
   logic [ffcc_pkg::POS_W-1:0]     entry_pos;
   logic [ffcc_pkg::POS_W-1:0]     zero_count;
   int unsigned                    entry_limit;

   logic [ffcc_pkg::CLUSTER_W-1:0] free_count_q[$];
   stim_row_type                   directed [DIRECTED_ROWS];
   int                             mismatches  = 0;
   int unsigned                    cycle_count = 0;
   int                             bytes_sent  = 0;
   logic                           steady      = 1'b0;

   fat_free_cluster_counter DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   function automatic stim_row_type byte_row(logic [7:0] b, logic last);
      return '{kind: ROW_BYTE, index: '0, value: ffcc_pkg::CLUSTER_W'(b), last: last,
               typed: 1'b0, want: '0};
   endfunction

   // final byte of a table whose count is written down by hand
   function automatic stim_row_type typed_row(logic [7:0] b,
                                              logic [ffcc_pkg::CLUSTER_W-1:0] want);
      return '{kind: ROW_BYTE, index: '0, value: ffcc_pkg::CLUSTER_W'(b), last: 1'b1,
               typed: 1'b1, want: want};
   endfunction

   function automatic stim_row_type csr_row(logic [ffcc_pkg::CSR_IDX_W-1:0] index,
                                            logic [ffcc_pkg::CLUSTER_W-1:0] value);
      return '{kind: ROW_CSR, index: index, value: value, last: 1'b0,
               typed: 1'b0, want: '0};
   endfunction

   function automatic int draw_gap();
      return steady ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   function automatic void update_limit();
      int unsigned n;
      int unsigned cap;
      int unsigned top;
      n = 32'(table_bytes);
      if (n > 32'(ffcc_pkg::MAX_TABLE_BYTES)) n = 32'(ffcc_pkg::MAX_TABLE_BYTES);
      cap = mode_fat12 ? n * 2 / 3 : n / 2;
      top = 32'(clusters) + 2;
      entry_limit = (cap < top) ? cap : top;
   endfunction

   function automatic void clear_stream();
      byte_pos   = '0;
      held       = '0;
      entry_pos  = '0;
      zero_count = '0;
   endfunction

   function automatic void take_entry(logic [15:0] entry);
      if (entry_pos < entry_limit) begin
         if (entry_pos >= 2 && entry == '0) zero_count++;
         entry_pos++;
      end
   endfunction

   // advances the scan by one table byte, returns 1 with the count on the last one
   function automatic bit fold_byte(logic [7:0] b, logic last,
                                    output logic [ffcc_pkg::CLUSTER_W-1:0] free);
      int unsigned scanned;
      int unsigned extra;
      free = '0;
      if (mode_fat12) begin
         case (byte_pos % 3)
            0: held = b;
            1: begin
               take_entry({4'h0, b[3:0], held});
               held = b;
            end
            default: take_entry({4'h0, b, held[7:4]});
         endcase
      end else if (byte_pos[0]) begin
         take_entry({b, held});
      end else begin
         held = b;
      end
      if (byte_pos != ffcc_pkg::POS_MAX) byte_pos++;
      if (!last) return 1'b0;
      // clusters past the scanned range count as free
      scanned = (entry_limit >= 2) ? entry_limit - 2 : 0;
      extra   = (32'(clusters) > scanned) ? 32'(clusters) - scanned : 0;
      free    = ffcc_pkg::CLUSTER_W'(32'(zero_count) + extra);
      clear_stream();
      return 1'b1;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
   endtask

   // registers change only once every count is out and the scan has drained
   task automatic write_csr(logic [ffcc_pkg::CSR_IDX_W-1:0] index,
                            logic [ffcc_pkg::CLUSTER_W-1:0] value);
      int gap;
      gap = draw_gap();
      req_tvalid <= 1'b0;
      while (free_count_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES + gap) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      case (index)
         ffcc_pkg::CSR_IS_FAT12:      mode_fat12 = value[0];
         ffcc_pkg::CSR_FAT_BYTES:     table_bytes = value[ffcc_pkg::FAT_W-1:0];
         ffcc_pkg::CSR_CLUSTER_COUNT: clusters = value;
         default:                     return;
      endcase
      update_limit();
   endtask

   task automatic send_byte(logic [7:0] b, logic last, logic typed,
                            logic [ffcc_pkg::CLUSTER_W-1:0] want);
      int gap;
      logic [ffcc_pkg::CLUSTER_W-1:0] free;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      bytes_sent++;
      if (fold_byte(b, last, free)) free_count_q.push_back(typed ? want : free);
   endtask

   initial begin : drain_results
      int gap;
      logic [ffcc_pkg::CLUSTER_W-1:0] want;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         if (free_count_q.size() == 0) begin
            report_mismatch("count with none pending", rsp_tdata, '0);
         end else begin
            want = free_count_q.pop_front();
            if (rsp_tdata !== {4'b0, want})
               report_mismatch("free count", rsp_tdata, {4'b0, want});
         end
      end
   end

   initial begin : run
      stim_row_type                   row;
      int                             len;
      int                             pick;
      logic [ffcc_pkg::FAT_W-1:0]     fb;
      logic [ffcc_pkg::CLUSTER_W-1:0] cc;
      logic [ffcc_pkg::CLUSTER_W-1:0] wdata;
      logic [7:0]                     b;

      mode_fat12  = 1'b0;
      table_bytes = ffcc_pkg::FAT_BYTES_RESET;
      clusters    = ffcc_pkg::CLUSTER_RESET;
      clear_stream();
      update_limit();

      directed = '{
         // reset settings: 16-bit entries, limit of four
         byte_row(8'h00, 1'b0), byte_row(8'h00, 1'b0),
         byte_row(8'hFF, 1'b0), byte_row(8'hFF, 1'b0),
         byte_row(8'h00, 1'b0), typed_row(8'h00, 28'd1),
         // empty table and the largest cluster count: all clusters free
         csr_row(ffcc_pkg::CSR_IS_FAT12, 28'd1), csr_row(ffcc_pkg::CSR_FAT_BYTES, 28'd0),
         csr_row(ffcc_pkg::CSR_CLUSTER_COUNT, 28'hFFFFFFF), typed_row(8'hFF, 28'hFFFFFFF),
         // oversized table, no clusters
         csr_row(ffcc_pkg::CSR_FAT_BYTES, 28'h007FFFF),
         csr_row(ffcc_pkg::CSR_CLUSTER_COUNT, 28'd0),
         byte_row(8'h00, 1'b0), byte_row(8'h00, 1'b0), typed_row(8'h00, 28'd0),
         // packed entries with one cluster, nibbles split across neighbors
         csr_row(ffcc_pkg::CSR_FAT_BYTES, 28'd6), csr_row(ffcc_pkg::CSR_CLUSTER_COUNT, 28'd1),
         byte_row(8'h00, 1'b0), byte_row(8'hF0, 1'b0), byte_row(8'h00, 1'b0),
         byte_row(8'h00, 1'b0), byte_row(8'h0F, 1'b0), byte_row(8'h00, 1'b1),
         // back to 16-bit with stray upper data bits, then bytes past the table
         csr_row(ffcc_pkg::CSR_IS_FAT12, 28'hFFFFFFE),
         csr_row(ffcc_pkg::CSR_FAT_BYTES, 28'hFF80004),
         csr_row(ffcc_pkg::CSR_CLUSTER_COUNT, 28'd5), csr_row(CSR_UNUSED, 28'h5A5A5A5),
         byte_row(8'hFF, 1'b0), byte_row(8'hFF, 1'b0), byte_row(8'h00, 1'b0),
         byte_row(8'h00, 1'b0), byte_row(8'h00, 1'b0), byte_row(8'h00, 1'b1)
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         row = directed[i];
         if (row.kind == ROW_CSR) write_csr(row.index, row.value);
         else send_byte(row.value[ffcc_pkg::BYTE_W-1:0], row.last, row.typed, row.want);
      end

      while (bytes_sent < ITEM_TARGET) begin
         steady = ($urandom_range(0, 3) == 0);

         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            fb = ffcc_pkg::FAT_W'($urandom_range(0, 48));
         end else if (pick < 9) begin
            fb = ffcc_pkg::FAT_W'($urandom_range(49, 600));
         end else begin
            case ($urandom_range(0, 2))
               0: fb = ffcc_pkg::MAX_TABLE_BYTES;
               1: fb = '1;
               default: fb = ffcc_pkg::FAT_W'($urandom_range(601, 2**ffcc_pkg::FAT_W - 1));
            endcase
         end

         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: cc = ffcc_pkg::CLUSTER_W'($urandom_range(0, 60));
            6, 7: cc = ffcc_pkg::CLUSTER_W'($urandom);
            8: cc = '1;
            default: cc = ffcc_pkg::CLUSTER_W'($urandom_range(0, 1));
         endcase

         // upper data bits beyond a register's width are don't-care
         if ($urandom_range(0, 2) != 0) begin
            wdata = $urandom_range(0, 1) ? ffcc_pkg::CLUSTER_W'($urandom) : '0;
            wdata[0] = 1'($urandom_range(0, 1));
            write_csr(ffcc_pkg::CSR_IS_FAT12, wdata);
         end
         if ($urandom_range(0, 2) != 0) begin
            wdata = $urandom_range(0, 1) ? ffcc_pkg::CLUSTER_W'($urandom) : '0;
            wdata[ffcc_pkg::FAT_W-1:0] = fb;
            write_csr(ffcc_pkg::CSR_FAT_BYTES, wdata);
         end
         if ($urandom_range(0, 2) != 0) write_csr(ffcc_pkg::CSR_CLUSTER_COUNT, cc);
         if ($urandom_range(0, 9) == 0) write_csr(CSR_UNUSED, ffcc_pkg::CLUSTER_W'($urandom));

         repeat ($urandom_range(1, 4)) begin
            if (bytes_sent >= ITEM_TARGET) break;
            // huge tables are only ever cut short
            len = (table_bytes > 600) ? $urandom_range(1, 40) : int'(table_bytes);
            pick = $urandom_range(0, 19);
            if (len == 0) len = $urandom_range(1, 3);
            else if (pick < 3) len = $urandom_range(1, len);
            else if (pick < 5) len = len + $urandom_range(1, 8);
            // the final table is cut to the item budget
            if (len > ITEM_TARGET - bytes_sent) len = ITEM_TARGET - bytes_sent;
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4: b = 8'h00;
                  5: b = 8'hF0;
                  6: b = 8'h0F;
                  default: b = 8'($urandom);
               endcase
               send_byte(b, i == len - 1, 1'b0, '0);
            end
         end
      end

      req_tvalid <= 1'b0;
      while (free_count_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/ffcc_pkg.sv
design/ffcc_cfg.sv
design/ffcc_scan.sv
design/fat_free_cluster_counter.sv
test/fat_free_cluster_counter_tb.sv
